### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the block pool allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

### rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Block pool allocator package
// Fixed widths, request and status codes, register indexes and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

  // Request codes
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  // Response codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_reg_e;

  // Request sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

`default_nettype wire

### rtl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: hold data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// Fixed-size block pool allocator
// A request is taken in the idle state and its response is registered in the
// execute state once the response register can advance; no new request is
// taken before then, as the read-modify-write of the block memory reads at
// accept and writes back in the execute state. Reset: free list empty, fresh
// counter 0, no block allocated, base 0, count 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fixed_block_pool_allocator #(
  parameter int unsigned POOL_BLOCKS = 1024,
  parameter int unsigned BLOCK_BYTES = 32   // power of two
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          opcode_i,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]         address_i,
  // Response channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [1:0]                               status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]              block_address_o
);

  localparam int unsigned AW      = fbpa_pkg::ADDR_W;
  localparam int unsigned IDX_W   = $clog2(POOL_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned OFFS_W  = $clog2(BLOCK_BYTES);
  localparam int unsigned BIDX_W  = AW - OFFS_W;
  localparam int unsigned ENT_W   = IDX_W + 2;
  localparam logic [AW-1:0] POOL_BLOCKS_W = AW'(POOL_BLOCKS);

  // One memory entry: allocated flag plus the link to the next freed block
  typedef struct packed {
    logic             alloc;
    logic             lvalid;
    logic [IDX_W-1:0] link;
  } entry_t;

  // Configuration registers
  logic [AW-1:0]                    pool_base_q;
  logic [fbpa_pkg::COUNT_W-1:0]     block_count_q;

  // Pool state
  logic [IDX_W-1:0] free_head_q, free_head_d;
  logic             head_valid_q, head_valid_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;

  // Request registers
  fbpa_pkg::state_e  state_q, state_d;
  fbpa_pkg::opcode_e op_q;
  logic [IDX_W-1:0]  idx_q;
  logic              bad_q;
  logic              below_fresh_q;
  logic              use_list_q;
  logic              avail_q;

  // Response registers
  logic                  out_valid_q, out_valid_d;
  fbpa_pkg::status_e     status_q, status_d;
  logic [AW-1:0]         block_address_q, block_address_d;

  // Decode signals
  fbpa_pkg::opcode_e in_op;
  logic              in_accept;
  logic [AW-1:0]     offset;
  logic [BIDX_W-1:0] free_bidx;
  logic [AW-1:0]     eff_count;
  logic              addr_bad;
  logic              fresh_ok;
  logic [IDX_W-1:0]  idx_d;

  // Memory ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;
  logic             advance;
  logic             out_load;

  // Hold configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= '0;
      block_count_q <= fbpa_pkg::BLOCK_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (fbpa_pkg::cfg_reg_e'(cfg_index_i))
        fbpa_pkg::CFG_POOL_BASE:   pool_base_q   <= cfg_data_i;
        fbpa_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[fbpa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the block count to the pool size
  assign eff_count = (AW'(block_count_q) > POOL_BLOCKS_W) ? POOL_BLOCKS_W
                                                            : AW'(block_count_q);

  // Decode the incoming request
  assign in_op     = fbpa_pkg::opcode_e'(opcode_i);
  assign in_ready_o = (state_q == fbpa_pkg::S_IDLE);
  assign in_accept = in_valid_i && in_ready_o;
  assign offset    = address_i - pool_base_q;
  assign free_bidx = offset[AW-1:OFFS_W];
  assign addr_bad  = (address_i == '0) || (address_i < pool_base_q)
                   || (|offset[OFFS_W-1:0]) || (AW'(free_bidx) >= eff_count);
  assign fresh_ok  = AW'(fresh_q) < eff_count;

  always_comb begin
    idx_d  = free_bidx[IDX_W-1:0];
    ram_re = 1'b0;
    case (in_op)
      fbpa_pkg::OP_ALLOC: begin
        idx_d  = head_valid_q ? free_head_q : fresh_q[IDX_W-1:0];
        ram_re = in_accept && head_valid_q;
      end
      fbpa_pkg::OP_FREE: begin
        ram_re = in_accept;
      end
      default: ;
    endcase
  end

  // Latch the request at accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q          <= in_op;
      idx_q         <= idx_d;
      bad_q         <= addr_bad;
      below_fresh_q <= AW'(free_bidx) < AW'(fresh_q);
      use_list_q    <= head_valid_q;
      avail_q       <= head_valid_q || fresh_ok;
    end
  end

  // Block memory: allocated flag and free-list link per block
  fbpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (POOL_BLOCKS)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  assign advance  = !out_valid_q || out_ready_i;
  assign out_load = (state_q == fbpa_pkg::S_EXEC) && advance;
  assign ram_waddr = idx_q;

  // Sequence the request and update the pool state
  always_comb begin
    state_d         = state_q;
    free_head_d     = free_head_q;
    head_valid_d    = head_valid_q;
    fresh_d         = fresh_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    status_d        = status_q;
    block_address_d = block_address_q;
    ram_we          = 1'b0;
    ram_wdata       = '0;

    case (state_q)
      fbpa_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = fbpa_pkg::S_EXEC;
        end
      end
      fbpa_pkg::S_EXEC: begin
        if (advance) begin
          state_d         = fbpa_pkg::S_IDLE;
          out_valid_d     = 1'b1;
          status_d        = fbpa_pkg::ST_OK;
          block_address_d = '0;
          case (op_q)
            fbpa_pkg::OP_ALLOC: begin
              if (avail_q) begin
                block_address_d = pool_base_q + (AW'(idx_q) << OFFS_W);
                ram_we          = 1'b1;
                ram_wdata.alloc = 1'b1;
                if (use_list_q) begin
                  free_head_d  = ram_rdata.link;
                  head_valid_d = ram_rdata.lvalid;
                end else begin
                  fresh_d = fresh_q + CNT_W'(1);
                end
              end else begin
                status_d = fbpa_pkg::ST_EMPTY;
              end
            end
            fbpa_pkg::OP_FREE: begin
              // Blocks at or above the fresh counter were never handed out
              if (bad_q) begin
                status_d = fbpa_pkg::ST_BAD_ADDR;
              end else if (!(below_fresh_q && ram_rdata.alloc)) begin
                status_d = fbpa_pkg::ST_NOT_ALLOC;
              end else begin
                ram_we           = 1'b1;
                ram_wdata.alloc  = 1'b0;
                ram_wdata.lvalid = head_valid_q;
                ram_wdata.link   = free_head_q;
                free_head_d      = idx_q;
                head_valid_d     = 1'b1;
              end
            end
            fbpa_pkg::OP_REINIT: begin
              head_valid_d = 1'b0;
              fresh_d      = '0;
            end
            default: ;
          endcase
        end
      end
      default: state_d = fbpa_pkg::S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fbpa_pkg::S_IDLE;
      head_valid_q <= 1'b0;
      fresh_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_valid_q <= head_valid_d;
      fresh_q      <= fresh_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    free_head_q     <= free_head_d;
    status_q        <= status_d;
    block_address_q <= block_address_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign block_address_o = block_address_q;

  // Assertions
  `ASSERT_AT(a_we_in_exec, clk_i, rst_ni,
    ram_we |-> (state_q == fbpa_pkg::S_EXEC) && advance,
    "block memory written outside the execute step")
  `ASSERT_NEVER(a_fresh_bound, clk_i, rst_ni,
    AW'(fresh_q) > POOL_BLOCKS_W,
    "fresh counter beyond pool size")
  `ASSERT_AT(a_idle_after_load, clk_i, rst_ni,
    out_load |=> (state_q == fbpa_pkg::S_IDLE) && out_valid_q,
    "response load did not return to idle")
  `ASSERT_AT(a_head_from_free, clk_i, rst_ni,
    $rose(head_valid_q) |-> ($past(op_q) == fbpa_pkg::OP_FREE),
    "free list became non-empty without a free")

endmodule

`default_nettype wire

### verif/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Sends alloc, free, reinit and unused-opcode requests over the valid/ready
// request channel. A scoreboard tracks its own copy of the free list and
// allocated flags and checks every response in order. Pool base and block
// count change between phases, while the block is idle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;

  localparam int unsigned POOL_SIZE      = 1024;
  localparam int unsigned BLOCK_SIZE     = 32;
  localparam int unsigned LONG_HOLD      = 120;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  typedef struct packed {
    fbpa_pkg::status_e           status;
    logic [fbpa_pkg::ADDR_W-1:0] block_address;
  } response_t;

  // Free-list tracker and in-order response checker
  class pool_scoreboard;
    logic [fbpa_pkg::ADDR_W-1:0]  base;
    logic [fbpa_pkg::COUNT_W-1:0] count;
    int unsigned                  link [POOL_SIZE];
    bit                           link_valid [POOL_SIZE];
    bit                           allocated [POOL_SIZE];
    int unsigned                  head;
    bit                           head_valid;
    int unsigned                  fresh;
    response_t                    expected_q [$];
    int unsigned                  failures;
    int unsigned                  requests;
    int unsigned                  status_seen [4];

    function new();
      base  = '0;
      count = fbpa_pkg::BLOCK_COUNT_RESET;
    endfunction

    function void write_register(fbpa_pkg::cfg_reg_e idx,
                                 logic [fbpa_pkg::CFG_DATA_W-1:0] data);
      if (idx == fbpa_pkg::CFG_POOL_BASE) base = data;
      else count = data[fbpa_pkg::COUNT_W-1:0];
    endfunction

    // Saturate the programmed count to the pool size
    function int unsigned usable_blocks();
      return (count > POOL_SIZE) ? POOL_SIZE : int'(count);
    endfunction

    function logic [fbpa_pkg::ADDR_W-1:0] block_addr(int unsigned idx);
      return base + idx * BLOCK_SIZE;
    endfunction

    // Find some allocated block, starting at a random index
    function bit pick_allocated(output logic [fbpa_pkg::ADDR_W-1:0] addr);
      int unsigned start;
      int unsigned idx;
      start = $urandom_range(0, POOL_SIZE - 1);
      for (int unsigned k = 0; k < POOL_SIZE; k++) begin
        idx = (start + k) % POOL_SIZE;
        if (allocated[idx]) begin
          addr = block_addr(idx);
          return 1'b1;
        end
      end
      addr = '0;
      return 1'b0;
    endfunction

    // Apply one accepted request and queue its response
    function void note_request(fbpa_pkg::opcode_e op, logic [fbpa_pkg::ADDR_W-1:0] addr);
      response_t                   rsp;
      logic [fbpa_pkg::ADDR_W-1:0] offset;
      int unsigned                 idx;
      bit                          got;
      rsp.status        = fbpa_pkg::ST_OK;
      rsp.block_address = '0;
      got = 1'b0;
      idx = 0;
      case (op)
        fbpa_pkg::OP_ALLOC: begin
          // Pop freed blocks first, then hand out never-used ones
          if (head_valid) begin
            idx        = head;
            head_valid = link_valid[idx];
            head       = link[idx];
            got        = 1'b1;
          end else if (fresh < usable_blocks()) begin
            idx   = fresh;
            fresh = fresh + 1;
            got   = 1'b1;
          end
          if (got) begin
            allocated[idx]    = 1'b1;
            rsp.block_address = block_addr(idx);
          end else begin
            rsp.status = fbpa_pkg::ST_EMPTY;
          end
        end
        fbpa_pkg::OP_FREE: begin
          offset = addr - base;
          idx    = offset / BLOCK_SIZE;
          if ((addr == '0) || (addr < base) || ((offset % BLOCK_SIZE) != 0) ||
              (idx >= usable_blocks())) begin
            rsp.status = fbpa_pkg::ST_BAD_ADDR;
          end else if (!allocated[idx]) begin
            rsp.status = fbpa_pkg::ST_NOT_ALLOC;
          end else begin
            // Push the block in front of the free list
            allocated[idx]  = 1'b0;
            link[idx]       = head;
            link_valid[idx] = head_valid;
            head            = idx;
            head_valid      = 1'b1;
          end
        end
        fbpa_pkg::OP_REINIT: begin
          foreach (allocated[i]) allocated[i] = 1'b0;
          head       = 0;
          head_valid = 1'b0;
          fresh      = 0;
        end
        default: begin
        end
      endcase
      requests = requests + 1;
      expected_q.push_back(rsp);
    endfunction

    // Compare one response against the oldest expectation
    function void check_response(logic [1:0] status, logic [fbpa_pkg::ADDR_W-1:0] addr);
      response_t want;
      if (expected_q.size() == 0) begin
        failures = failures + 1;
        $display("%0t: unexpected response, status %0d address %h", $time, status, addr);
        return;
      end
      want = expected_q.pop_front();
      status_seen[want.status] = status_seen[want.status] + 1;
      if (status !== want.status) begin
        failures = failures + 1;
        $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                 $time, want.status, want.status.name(), status);
      end
      if (addr !== want.block_address) begin
        failures = failures + 1;
        $display("%0t: block address mismatch, expected %h, actual %h",
                 $time, want.block_address, addr);
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [1:0]                      opcode_i;
  logic [fbpa_pkg::ADDR_W-1:0]     address_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [1:0]                      status_o;
  logic [fbpa_pkg::ADDR_W-1:0]     block_address_o;

  pool_scoreboard sb = new();

  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          idle_allowed    = 1'b1;
  bit          long_hold_req   = 1'b0;
  int unsigned phases          = 0;

  fixed_block_pool_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .block_address_o (block_address_o)
  );

  // Free-running clock
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Write base and count on back-to-back cycles; upper count bits are noise
  task automatic set_pool(logic [fbpa_pkg::ADDR_W-1:0] base,
                          logic [fbpa_pkg::COUNT_W-1:0] count);
    logic [fbpa_pkg::CFG_DATA_W-1:0] count_word;
    count_word = $urandom();
    count_word[fbpa_pkg::COUNT_W-1:0] = count;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= fbpa_pkg::CFG_POOL_BASE;
    cfg_data_i  <= base;
    @(posedge clk_i);
    sb.write_register(fbpa_pkg::CFG_POOL_BASE, base);
    cfg_index_i <= fbpa_pkg::CFG_BLOCK_COUNT;
    cfg_data_i  <= count_word;
    @(posedge clk_i);
    sb.write_register(fbpa_pkg::CFG_BLOCK_COUNT, count_word);
    cfg_we_i <= 1'b0;
    phases = phases + 1;
  endtask

  // Offer one request and hold it until accepted
  task automatic send_request(fbpa_pkg::opcode_e op, logic [fbpa_pkg::ADDR_W-1:0] addr);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, addr);
  endtask

  // Drop valid and wait for every outstanding response
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed alloc/free traffic, with some bad frees and noise
  function automatic void pick_request(output fbpa_pkg::opcode_e op,
                                       output logic [fbpa_pkg::ADDR_W-1:0] addr);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    addr = $urandom();
    if (roll < 45) begin
      op = fbpa_pkg::OP_ALLOC;
    end else if (roll < 80) begin
      op = fbpa_pkg::OP_FREE;
      if (!sb.pick_allocated(addr)) addr = sb.block_addr($urandom_range(0, 3));
    end else if (roll < 88) begin
      // aligned block, often free or just past the end
      op   = fbpa_pkg::OP_FREE;
      addr = sb.block_addr($urandom_range(0, sb.usable_blocks() + 1));
    end else if (roll < 94) begin
      op = fbpa_pkg::OP_FREE;
      case ($urandom_range(0, 3))
        0: addr = sb.block_addr($urandom_range(0, 7)) + $urandom_range(1, BLOCK_SIZE - 1);
        1: addr = sb.base - $urandom_range(1, 64);
        2: addr = '0;
        default: begin
        end
      endcase
    end else if (roll < 97) begin
      op = fbpa_pkg::OP_NOP;
    end else begin
      op = fbpa_pkg::OP_REINIT;
    end
  endfunction

  // One configuration phase of random requests
  task automatic run_random(int unsigned n, logic [fbpa_pkg::ADDR_W-1:0] base,
                            logic [fbpa_pkg::COUNT_W-1:0] count, bit hold_mid);
    fbpa_pkg::opcode_e           op;
    logic [fbpa_pkg::ADDR_W-1:0] addr;
    set_pool(base, count);
    for (int unsigned i = 0; i < n; i++) begin
      // alternate stretches with and without idling
      if (idle_allowed) begin
        sender_gaps     = (i % 100) < 70;
        receiver_stalls = ((i + 50) % 100) < 70;
      end
      if (hold_mid && i == n / 2) long_hold_req = 1'b1;
      pick_request(op, addr);
      send_request(op, addr);
    end
    wait_idle();
  endtask

  // Response side: random stalls plus one long hold on request
  initial begin : response_sink
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_response(status_o, block_address_o);
    end
  end

  // Abort when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("%0t: no request or response moved for %0d cycles", $time, quiet);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    in_valid_i  <= 1'b0;
    opcode_i    <= fbpa_pkg::OP_NOP;
    address_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= fbpa_pkg::CFG_POOL_BASE;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Three-block pool: empty pool, bad frees, double free, LIFO reuse
    set_pool(32'h0000_1000, 11'd3);
    send_request(fbpa_pkg::OP_FREE, 32'h0000_0000);
    repeat (4) send_request(fbpa_pkg::OP_ALLOC, $urandom());
    send_request(fbpa_pkg::OP_FREE, 32'h0000_0FE0);
    send_request(fbpa_pkg::OP_FREE, 32'h0000_1010);
    send_request(fbpa_pkg::OP_FREE, 32'h0000_1060);
    send_request(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);
    send_request(fbpa_pkg::OP_FREE, 32'h0000_1020);
    send_request(fbpa_pkg::OP_FREE, 32'h0000_1020);
    send_request(fbpa_pkg::OP_FREE, 32'h0000_1000);
    repeat (3) send_request(fbpa_pkg::OP_ALLOC, $urandom());
    send_request(fbpa_pkg::OP_NOP, 32'hFFFF_FFFF);
    send_request(fbpa_pkg::OP_REINIT, $urandom());
    send_request(fbpa_pkg::OP_FREE, 32'h0000_1000);
    wait_idle();

    // Base near the top: the third block wraps to address zero
    set_pool(32'hFFFF_FFC0, 11'd4);
    repeat (3) send_request(fbpa_pkg::OP_ALLOC, $urandom());
    send_request(fbpa_pkg::OP_FREE, 32'h0000_0000);
    send_request(fbpa_pkg::OP_FREE, 32'hFFFF_FFE0);
    wait_idle();

    // Block zero at address zero still rejects a null free
    set_pool(32'h0000_0000, 11'd2);
    send_request(fbpa_pkg::OP_ALLOC, $urandom());
    send_request(fbpa_pkg::OP_FREE, 32'h0000_0000);
    wait_idle();

    // Random phases; config changes keep the pool state
    run_random(300, $urandom() & 32'hFFFF_FFE0, 11'd1024, 1'b1);
    run_random(200, 32'hFFFF_FF00, 11'd16, 1'b0);
    run_random(150, 32'hFFFF_FFFF, 11'h7FF, 1'b0);
    run_random(60, 32'h0000_0000, 11'd0, 1'b0);
    run_random(150, $urandom(), 11'd1, 1'b0);
    run_random(250, $urandom(), 11'($urandom_range(1, 64)), 1'b0);

    // Closing phase at full rate
    idle_allowed    = 1'b0;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_random(280, $urandom() & 32'hFFFF_FFE0, 11'($urandom_range(2, 40)), 1'b0);

    $display("Covered %0d requests over %0d pool settings, with a %0d-cycle output hold.",
             sb.requests, phases, LONG_HOLD);
    $display("Responses: %0d ok, %0d pool empty, %0d bad address, %0d not allocated.",
             sb.status_seen[fbpa_pkg::ST_OK], sb.status_seen[fbpa_pkg::ST_EMPTY],
             sb.status_seen[fbpa_pkg::ST_BAD_ADDR], sb.status_seen[fbpa_pkg::ST_NOT_ALLOC]);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
